// ===== design/lorenz_rk4_integrator_step_defines.svh =====
// Assertion macros used by the checker file of the Lorenz RK4 integrator.
`ifndef LORENZ_RK4_INTEGRATOR_STEP_DEFINES_SVH
`define LORENZ_RK4_INTEGRATOR_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define LRK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define LRK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lrk_pkg.sv =====
// Package with widths, codes, reset values and helper functions of the Lorenz RK4 integrator.
`default_nettype none
package lrk_pkg;

   localparam int unsigned StateW   = 32;
   localparam int unsigned DerivW   = 40;
   localparam int unsigned FracW    = 24;
   localparam int unsigned CoefW    = 31;
   localparam int unsigned StepW    = 24;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 32;

   localparam int unsigned AccW     = 44;
   localparam int unsigned OpAW     = 44;
   localparam int unsigned AMagW    = 43;
   localparam int unsigned OpBW     = 33;
   localparam int unsigned BMagW    = 32;
   localparam int unsigned DigitW   = 8;
   localparam int unsigned MulSteps = BMagW / DigitW;
   localparam int unsigned MulCntW  = $clog2(MulSteps);
   localparam int unsigned PartW    = AMagW + DigitW;
   localparam int unsigned ProdW    = AMagW + BMagW;
   localparam int unsigned WideW    = 52;
   localparam int unsigned DivW     = 44;
   localparam int unsigned DivDigW  = 4;
   localparam int unsigned DivSteps = DivW / DivDigW;
   localparam int unsigned DivCntW  = $clog2(DivSteps);

   localparam logic [CoefW-1:0]         SigmaRst = 31'd167772160;
   localparam logic [CoefW-1:0]         BetaRst  = 31'd44739243;
   localparam logic [StepW-1:0]         StepRst  = 24'd134218;
   localparam logic signed [StateW-1:0] InitXRst = 32'sd33554432;
   localparam logic signed [StateW-1:0] InitYRst = 32'sd0;
   localparam logic signed [StateW-1:0] InitZRst = 32'sd0;

   localparam logic OpcReload = 1'b0;
   localparam logic OpcStep   = 1'b1;

   localparam logic [CsrIdxW-1:0] CsrSigma = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrBeta  = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrStep  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrInitX = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrInitY = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrInitZ = 3'd5;

   localparam logic signed [WideW-1:0] DerivHi = WideW'((64'sd1 <<< (DerivW - 1)) - 64'sd1);
   localparam logic signed [WideW-1:0] DerivLo = -DerivHi - WideW'(1);
   localparam logic signed [WideW-1:0] StateHi = WideW'((64'sd1 <<< (StateW - 1)) - 64'sd1);
   localparam logic signed [WideW-1:0] StateLo = -StateHi - WideW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_POST,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_SG,
      OP_RX,
      OP_XY,
      OP_BZ,
      OP_STG,
      OP_UPD
   } op_type;

   typedef struct packed {
      logic [DivDigW-1:0] q;
      logic [1:0]         r;
   } div3_type;

   function automatic logic sat_deriv_ovf(input logic signed [WideW-1:0] v);
      return (v > DerivHi) || (v < DerivLo);
   endfunction

   function automatic logic signed [DerivW-1:0] sat_deriv(input logic signed [WideW-1:0] v);
      if (v > DerivHi) begin
         return DerivHi[DerivW-1:0];
      end else if (v < DerivLo) begin
         return DerivLo[DerivW-1:0];
      end
      return v[DerivW-1:0];
   endfunction

   function automatic logic sat_state_ovf(input logic signed [WideW-1:0] v);
      return (v > StateHi) || (v < StateLo);
   endfunction

   function automatic logic signed [StateW-1:0] sat_state(input logic signed [WideW-1:0] v);
      if (v > StateHi) begin
         return StateHi[StateW-1:0];
      end else if (v < StateLo) begin
         return StateLo[StateW-1:0];
      end
      return v[StateW-1:0];
   endfunction

   // One radix-16 digit of a long division by three, most significant bit first.
   function automatic div3_type div3_digit(input logic [1:0] rem, input logic [DivDigW-1:0] dig);
      logic [2:0] r;
      div3_type   res;
      r = {1'b0, rem};
      for (int i = DivDigW - 1; i >= 0; i--) begin
         r = {r[1:0], dig[i]};
         if (r >= 3'd3) begin
            res.q[i] = 1'b1;
            r        = r - 3'd3;
         end else begin
            res.q[i] = 1'b0;
         end
      end
      res.r = r[1:0];
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== design/lrk_req_if.sv =====
// Step request channel: opcode and rho with valid and ready.
`default_nettype none
interface lrk_req_if import lrk_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [StateW-1:0] rho;

   modport source (output valid, output opcode, output rho, input ready);
   modport sink (input valid, input opcode, input rho, output ready);
endinterface
`default_nettype wire

// ===== design/lrk_rsp_if.sv =====
// Result channel: new x, y, z and the saturation flag with valid and ready.
`default_nettype none
interface lrk_rsp_if import lrk_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [StateW-1:0] out_x;
   logic signed [StateW-1:0] out_y;
   logic signed [StateW-1:0] out_z;
   logic                     saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output saturated,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, input saturated,
                 output ready);
endinterface
`default_nettype wire

// ===== design/lrk_csr_if.sv =====
// Configuration write channel: register index and write data with valid and ready.
`default_nettype none
interface lrk_csr_if import lrk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lorenz_rk4_integrator_step.sv =====
// Lorenz RK4 step: each step item runs 28 products on one 43x8 digit-serial multiplier plus
// three radix-16 divides by three. A new item is taken the cycle after the result is loaded.
// Synchronous reset restores the default coefficients and the state (2, 0, 0).
`default_nettype none
module lorenz_rk4_integrator_step import lrk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lrk_req_if.sink   req_ch,
   lrk_rsp_if.source rsp_ch,
   lrk_csr_if.sink   csr_ch
);

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [1:0]               rk_ff, rk_in;
   logic [1:0]               idx_ff, idx_in;
   logic [MulCntW-1:0]       cnt_ff, cnt_in;
   logic [DivCntW-1:0]       dcnt_ff, dcnt_in;
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [CoefW-1:0]         sigma_ff, sigma_in;
   logic [CoefW-1:0]         beta_ff, beta_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic signed [StateW-1:0] init_x_ff, init_x_in;
   logic signed [StateW-1:0] init_y_ff, init_y_in;
   logic signed [StateW-1:0] init_z_ff, init_z_in;
   logic signed [StateW-1:0] x_ff [3];
   logic signed [StateW-1:0] x_in [3];

   logic signed [StateW-1:0] pt_ff [3];
   logic signed [StateW-1:0] pt_in [3];
   logic signed [DerivW-1:0] k_ff [3];
   logic signed [DerivW-1:0] k_in [3];
   logic signed [AccW-1:0]   acc_ff [3];
   logic signed [AccW-1:0]   acc_in [3];
   logic signed [WideW-1:0]  tmp_ff, tmp_in;
   logic signed [StateW-1:0] rho_ff, rho_in;
   logic [AMagW-1:0]         a_mag_ff, a_mag_in;
   logic [BMagW-1:0]         b_sh_ff, b_sh_in;
   logic [ProdW-1:0]         prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic [DivW-1:0]          div_sh_ff, div_sh_in;
   logic [1:0]               rem_ff, rem_in;
   logic [DivW-1:0]          quo_ff, quo_in;
   logic signed [StateW-1:0] out_x_ff, out_x_in;
   logic signed [StateW-1:0] out_y_ff, out_y_in;
   logic signed [StateW-1:0] out_z_ff, out_z_in;
   logic                     out_sat_ff, out_sat_in;

   logic signed [OpAW-1:0]   opa;
   logic signed [OpBW-1:0]   opb;
   logic [OpAW-1:0]          a_abs;
   logic [OpBW-1:0]          b_abs;
   logic [PartW-1:0]         partial;
   logic [ProdW-1:0]         r24;
   logic [ProdW-1:0]         r25;
   logic [ProdW-1:0]         nq;
   logic [WideW-2:0]         rmag;
   logic signed [WideW-1:0]  rs;
   logic signed [WideW-1:0]  w;
   logic signed [WideW-1:0]  qs;
   logic signed [DerivW-1:0] kv [3];
   logic                     wt2;
   div3_type                 dres;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_x     = out_x_ff;
   assign rsp_ch.out_y     = out_y_ff;
   assign rsp_ch.out_z     = out_z_ff;
   assign rsp_ch.saturated = out_sat_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (op_ff)
         OP_SG: begin
            opa = OpAW'(pt_ff[1]) - OpAW'(pt_ff[0]);
            opb = OpBW'({1'b0, sigma_ff});
         end
         OP_RX: begin
            opa = OpAW'(rho_ff) - OpAW'(pt_ff[2]);
            opb = OpBW'(pt_ff[0]);
         end
         OP_XY: begin
            opa = OpAW'(pt_ff[0]);
            opb = OpBW'(pt_ff[1]);
         end
         OP_BZ: begin
            opa = OpAW'(pt_ff[2]);
            opb = OpBW'({1'b0, beta_ff});
         end
         OP_STG: begin
            opa = OpAW'(k_ff[idx_ff]);
            opb = OpBW'({1'b0, step_ff});
         end
         OP_UPD: begin
            opa = acc_ff[idx_ff];
            opb = OpBW'({1'b0, step_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      a_abs = opa[OpAW-1] ? -opa : opa;
      b_abs = opb[OpBW-1] ? -opb : opb;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rk_in        = rk_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      dcnt_in      = dcnt_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      sigma_in     = sigma_ff;
      beta_in      = beta_ff;
      step_in      = step_ff;
      init_x_in    = init_x_ff;
      init_y_in    = init_y_ff;
      init_z_in    = init_z_ff;
      x_in         = x_ff;
      pt_in        = pt_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      rho_in       = rho_ff;
      a_mag_in     = a_mag_ff;
      b_sh_in      = b_sh_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      div_sh_in    = div_sh_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_sat_in   = out_sat_ff;

      partial = PartW'(a_mag_ff) * PartW'(b_sh_ff[BMagW-1 -: DigitW]);
      r24     = (prod_ff + (ProdW'(1) << (FracW - 1))) >> FracW;
      r25     = (prod_ff + (ProdW'(1) << FracW)) >> (FracW + 1);
      nq      = (prod_ff + (ProdW'(3) << FracW)) >> (FracW + 1);
      // Stage points built from k1 and k2 use half the step, hence one more bit of shift.
      rmag    = (op_ff == OP_STG && rk_ff != 2'd2) ? r25[WideW-2:0] : r24[WideW-2:0];
      rs      = neg_ff ? -WideW'(rmag) : WideW'(rmag);
      qs      = neg_ff ? -WideW'(quo_ff) : WideW'(quo_ff);
      w       = '0;
      kv      = k_ff;
      wt2     = (rk_ff == 2'd1) || (rk_ff == 2'd2);
      dres    = div3_digit(rem_ff, div_sh_ff[DivW-1 -: DivDigW]);

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CsrSigma: sigma_in  = csr_ch.data[CoefW-1:0];
            CsrBeta:  beta_in   = csr_ch.data[CoefW-1:0];
            CsrStep:  step_in   = csr_ch.data[StepW-1:0];
            CsrInitX: init_x_in = csr_ch.data;
            CsrInitY: init_y_in = csr_ch.data;
            CsrInitZ: init_z_in = csr_ch.data;
            default: ;
         endcase
      end

      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sat_in = 1'b0;
               if (req_ch.opcode == OpcReload) begin
                  x_in[0]  = init_x_ff;
                  x_in[1]  = init_y_ff;
                  x_in[2]  = init_z_ff;
                  state_in = ST_DONE;
               end else begin
                  rho_in   = req_ch.rho;
                  pt_in    = x_ff;
                  acc_in   = '{default: '0};
                  rk_in    = 2'd0;
                  idx_in   = 2'd0;
                  op_in    = OP_SG;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            a_mag_in = a_abs[AMagW-1:0];
            b_sh_in  = b_abs[BMagW-1:0];
            neg_in   = opa[OpAW-1] ^ opb[OpBW-1];
            prod_in  = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // One multiplier digit per cycle, most significant digit first.
            prod_in = (prod_ff << DigitW) + ProdW'(partial);
            b_sh_in = b_sh_ff << DigitW;
            cnt_in  = cnt_ff + MulCntW'(1);
            if (cnt_ff == MulCntW'(MulSteps - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = ST_LOAD;
            case (op_ff)
               OP_SG: begin
                  w       = rs;
                  k_in[0] = sat_deriv(w);
                  sat_in  = sat_ff | sat_deriv_ovf(w);
                  op_in   = OP_RX;
               end
               OP_RX: begin
                  w       = rs - WideW'(pt_ff[1]);
                  k_in[1] = sat_deriv(w);
                  sat_in  = sat_ff | sat_deriv_ovf(w);
                  op_in   = OP_XY;
               end
               OP_XY: begin
                  tmp_in = rs;
                  op_in  = OP_BZ;
               end
               OP_BZ: begin
                  w       = tmp_ff - rs;
                  kv[2]   = sat_deriv(w);
                  k_in[2] = kv[2];
                  sat_in  = sat_ff | sat_deriv_ovf(w);
                  for (int i = 0; i < 3; i++) begin
                     acc_in[i] = acc_ff[i] + (wt2 ? (AccW'(kv[i]) <<< 1) : AccW'(kv[i]));
                  end
                  idx_in = 2'd0;
                  op_in  = (rk_ff == 2'd3) ? OP_UPD : OP_STG;
               end
               OP_STG: begin
                  w             = WideW'(x_ff[idx_ff]) + rs;
                  pt_in[idx_ff] = sat_state(w);
                  sat_in        = sat_ff | sat_state_ovf(w);
                  if (idx_ff == 2'd2) begin
                     idx_in = 2'd0;
                     rk_in  = rk_ff + 2'd1;
                     op_in  = OP_SG;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               OP_UPD: begin
                  // Rounded quotient of h*sum by 6*2^24: halve first, then divide by three.
                  div_sh_in = nq[DivW-1:0];
                  rem_in    = 2'd0;
                  quo_in    = '0;
                  dcnt_in   = '0;
                  state_in  = ST_DIV;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            quo_in    = {quo_ff[DivW-DivDigW-1:0], dres.q};
            rem_in    = dres.r;
            div_sh_in = div_sh_ff << DivDigW;
            dcnt_in   = dcnt_ff + DivCntW'(1);
            if (dcnt_ff == DivCntW'(DivSteps - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            w            = WideW'(x_ff[idx_ff]) + qs;
            x_in[idx_ff] = sat_state(w);
            sat_in       = sat_ff | sat_state_ovf(w);
            if (idx_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_x_in     = x_ff[0];
               out_y_in     = x_ff[1];
               out_z_in     = x_ff[2];
               out_sat_in   = sat_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SG;
         rk_ff        <= 2'd0;
         idx_ff       <= 2'd0;
         cnt_ff       <= '0;
         dcnt_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sigma_ff     <= SigmaRst;
         beta_ff      <= BetaRst;
         step_ff      <= StepRst;
         init_x_ff    <= InitXRst;
         init_y_ff    <= InitYRst;
         init_z_ff    <= InitZRst;
         x_ff[0]      <= InitXRst;
         x_ff[1]      <= InitYRst;
         x_ff[2]      <= InitZRst;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rk_ff        <= rk_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         dcnt_ff      <= dcnt_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         sigma_ff     <= sigma_in;
         beta_ff      <= beta_in;
         step_ff      <= step_in;
         init_x_ff    <= init_x_in;
         init_y_ff    <= init_y_in;
         init_z_ff    <= init_z_in;
         x_ff         <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff      <= pt_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      tmp_ff     <= tmp_in;
      rho_ff     <= rho_in;
      a_mag_ff   <= a_mag_in;
      b_sh_ff    <= b_sh_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      div_sh_ff  <= div_sh_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_z_ff   <= out_z_in;
      out_sat_ff <= out_sat_in;
   end

endmodule
`default_nettype wire

// ===== design/lrk_checker.sv =====
// Port-level checker of the Lorenz RK4 integrator and its bind to the top level.
`default_nettype none
`include "lorenz_rk4_integrator_step_defines.svh"
module lrk_checker import lrk_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [StateW-1:0] rsp_out_x,
   input logic signed [StateW-1:0] rsp_out_y,
   input logic signed [StateW-1:0] rsp_out_z,
   input logic                     rsp_saturated
);

   logic                rsp_stall;
   logic [3*StateW:0]   rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated};

   // A stalled result keeps its valid and its payload.
   `LRK_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // The block works on one item at a time.
   `LRK_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second item taken while busy")

   // A new result appears exactly as the block frees its input.
   `LRK_ASSERT_NOW(a_rsp_frees_req, $rose(rsp_valid), req_ready, "result raised while still busy")

   // No result is left over from before reset.
   `LRK_ASSERT_NOW(a_clear_after_reset, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind lorenz_rk4_integrator_step lrk_checker u_lrk_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_x     (rsp_ch.out_x),
   .rsp_out_y     (rsp_ch.out_y),
   .rsp_out_z     (rsp_ch.out_z),
   .rsp_saturated (rsp_ch.saturated)
);
`default_nettype wire
